// ===== src/cskew_pkg.sv =====
// cskew_pkg: types and constants for the clock skew ratio estimator
// used by clock_skew_ratio_estimator and cskew_checker; no dependencies

package cskew_pkg;

   localparam int TS_BITS     = 40;
   localparam int FRAC_BITS   = 32;
   localparam int RATIO_BITS  = FRAC_BITS + 4;
   localparam int ALPHA_BITS  = 17;
   localparam int ALPHA_SHIFT = 16;
   localparam int HALF_BITS   = RATIO_BITS / 2;
   localparam int PROD_BITS   = ALPHA_BITS + HALF_BITS;
   localparam int ACC_BITS    = ALPHA_SHIFT + RATIO_BITS + 1;
   localparam int DIV_STEPS   = RATIO_BITS;
   localparam int CNT_BITS    = 6;
   localparam int MUL_STEPS   = 4;

   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE   = ALPHA_BITS'(65536);
   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(3277);
   localparam logic [RATIO_BITS-1:0] ONE_FIXED   = RATIO_BITS'(1) << FRAC_BITS;
   localparam logic [RATIO_BITS-1:0] RATIO_MAX   = {RATIO_BITS{1'b1}};
   localparam logic [ACC_BITS-1:0]   ROUND_HALF  = ACC_BITS'(1) << (ALPHA_SHIFT - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_MUL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [TS_BITS-1:0] master_tx_time;
      logic [TS_BITS-1:0] tag_rx_time;
   } req_payload_type;

   typedef struct packed {
      logic [RATIO_BITS-1:0] skew_ratio;
      logic                  was_fallback;
      logic                  saturated;
   } rsp_payload_type;

endpackage

// ===== src/clock_skew_ratio_estimator.sv =====
// clock_skew_ratio_estimator: smoothed master/tag clock ratio from timestamp pairs
// depends on cskew_pkg; one shared subtract unit for division, one 17x18 multiplier
//
// usage:
//  - req channel (valid/ready) carries a master transmit and a tag receive timestamp
//  - rsp channel (valid/ready) returns one result per request: Q4.32 ratio and flags
//  - csr_we/csr_wdata write the smoothing weight alpha (Q1.16) while the block is idle
// sequencing:
//  - fallback item (a stored timestamp is zero): goes straight to the finish state
//  - saturated item: skips the divider; normal item: runs the 36-step divider
//    loop, one quotient bit per cycle; both then run a multiply-accumulate
//  - req_ready is high only while the sequencer is idle, one item at a time; it returns
//    together with rsp_valid
// reset:
//  - synchronous, active high; clears stored timestamps and estimate, alpha to 3277
// stalls:
//  - a finished result sits in the output register until rsp_ready; the next item
//    may be taken and computed meanwhile, and it waits if the register is still full

module clock_skew_ratio_estimator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  cskew_pkg::req_payload_type             req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output cskew_pkg::rsp_payload_type             rsp_data,
   input  logic                                   csr_we,
   input  logic [cskew_pkg::ALPHA_BITS-1:0]       csr_wdata
);

   localparam int TSB = cskew_pkg::TS_BITS;
   localparam int RB  = cskew_pkg::RATIO_BITS;
   localparam int FB  = cskew_pkg::FRAC_BITS;
   localparam int AB  = cskew_pkg::ALPHA_BITS;
   localparam int HB  = cskew_pkg::HALF_BITS;
   localparam int PB  = cskew_pkg::PROD_BITS;
   localparam int CB  = cskew_pkg::ACC_BITS;
   localparam int NB  = cskew_pkg::CNT_BITS;
   localparam int AS  = cskew_pkg::ALPHA_SHIFT;

   cskew_pkg::state_type state_ff, state_in;

   logic [AB-1:0]  alpha_ff, alpha_in;
   logic [TSB-1:0] prev_m_ff, prev_m_in;
   logic [TSB-1:0] prev_t_ff, prev_t_in;
   logic [RB-1:0]  est_ff, est_in;
   logic [TSB-1:0] dm_ff, dm_in;
   logic [TSB-1:0] dt_ff, dt_in;
   logic [TSB-1:0] rem_ff, rem_in;
   logic [RB-1:0]  qn_ff, qn_in;
   logic [NB-1:0]  cnt_ff, cnt_in;
   logic [PB-1:0]  prod_ff, prod_in;
   logic           shift_ff, shift_in;
   logic [CB-1:0]  acc_ff, acc_in;
   logic           fallback_ff, fallback_in;
   logic           sat_ff, sat_in;
   logic           rsp_valid_ff, rsp_valid_in;
   cskew_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic           req_xfer;
   logic           prev_zero;
   logic           ratio_ge;
   logic           div_last;
   logic           mul_last;
   logic           out_free;
   logic           load_out;
   logic [AB-1:0]  alpha_clamp;
   logic [AB-1:0]  beta;
   logic [TSB:0]   div_trial;
   logic [TSB+1:0] div_diff;
   logic           div_take;
   logic [AB-1:0]  mul_x;
   logic [HB-1:0]  mul_y;
   logic [RB-1:0]  result;

   assign req_xfer  = req_valid && req_ready;
   assign prev_zero = (prev_m_ff == '0) || (prev_t_ff == '0);
   assign ratio_ge  = {4'b0, dm_ff} >= {dt_ff, 4'b0};
   assign div_last  = (cnt_ff == NB'(cskew_pkg::DIV_STEPS - 1));
   assign mul_last  = (cnt_ff == NB'(cskew_pkg::MUL_STEPS));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cskew_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = prev_zero ? cskew_pkg::ST_FINISH : cskew_pkg::ST_CHECK;
            end
         end
         cskew_pkg::ST_CHECK: begin
            state_in = ratio_ge ? cskew_pkg::ST_MUL : cskew_pkg::ST_DIV;
         end
         cskew_pkg::ST_DIV: begin
            if (div_last) begin
               state_in = cskew_pkg::ST_MUL;
            end
         end
         cskew_pkg::ST_MUL: begin
            if (mul_last) begin
               state_in = cskew_pkg::ST_FINISH;
            end
         end
         cskew_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = cskew_pkg::ST_IDLE;
            end
         end
         default: state_in = cskew_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         cskew_pkg::ST_IDLE:   req_ready = 1'b1;
         cskew_pkg::ST_FINISH: load_out  = out_free;
         default: begin
            req_ready = 1'b0;
            load_out  = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      alpha_clamp = (alpha_ff > cskew_pkg::ALPHA_ONE) ? cskew_pkg::ALPHA_ONE : alpha_ff;
      beta        = cskew_pkg::ALPHA_ONE - alpha_clamp;

      div_trial = {rem_ff, qn_ff[RB-1]};
      div_diff  = {1'b0, div_trial} - {2'b0, dt_ff};
      div_take  = !div_diff[TSB+1];

      mul_x = cnt_ff[1] ? beta : alpha_clamp;
      case (cnt_ff[1:0])
         2'd0:    mul_y = qn_ff[HB-1:0];
         2'd1:    mul_y = qn_ff[RB-1:HB];
         2'd2:    mul_y = est_ff[HB-1:0];
         default: mul_y = est_ff[RB-1:HB];
      endcase

      result = fallback_ff ? cskew_pkg::ONE_FIXED : acc_ff[AS+RB-1:AS];

      alpha_in    = csr_we ? csr_wdata : alpha_ff;
      prev_m_in   = prev_m_ff;
      prev_t_in   = prev_t_ff;
      est_in      = est_ff;
      dm_in       = dm_ff;
      dt_in       = dt_ff;
      rem_in      = rem_ff;
      qn_in       = qn_ff;
      cnt_in      = cnt_ff;
      prod_in     = prod_ff;
      shift_in    = shift_ff;
      acc_in      = acc_ff;
      fallback_in = fallback_ff;
      sat_in      = sat_ff;
      rsp_data_in = rsp_data_ff;

      if (req_xfer) begin
         dm_in       = req_data.master_tx_time - prev_m_ff;
         dt_in       = req_data.tag_rx_time - prev_t_ff;
         prev_m_in   = req_data.master_tx_time;
         prev_t_in   = req_data.tag_rx_time;
         fallback_in = prev_zero;
         sat_in      = 1'b0;
      end

      case (state_ff)
         cskew_pkg::ST_CHECK: begin
            // quotient below 16 leaves the top dividend bits as the remainder
            sat_in = ratio_ge;
            rem_in = TSB'(dm_ff[TSB-1:4]);
            qn_in  = ratio_ge ? cskew_pkg::RATIO_MAX : {dm_ff[3:0], {FB{1'b0}}};
            cnt_in = '0;
            acc_in = cskew_pkg::ROUND_HALF;
         end
         cskew_pkg::ST_DIV: begin
            rem_in = div_take ? div_diff[TSB-1:0] : div_trial[TSB-1:0];
            qn_in  = {qn_ff[RB-2:0], div_take};
            cnt_in = div_last ? '0 : cnt_ff + NB'(1);
         end
         cskew_pkg::ST_MUL: begin
            if (!mul_last) begin
               prod_in  = mul_x * mul_y;
               shift_in = cnt_ff[0];
            end
            if (cnt_ff != '0) begin
               acc_in = acc_ff + (shift_ff ? {prod_ff, {HB{1'b0}}} : CB'(prod_ff));
            end
            cnt_in = mul_last ? '0 : cnt_ff + NB'(1);
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase

      if (load_out) begin
         est_in                   = result;
         rsp_data_in.skew_ratio   = result;
         rsp_data_in.was_fallback = fallback_ff;
         rsp_data_in.saturated    = sat_ff;
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cskew_pkg::ST_IDLE;
         alpha_ff     <= cskew_pkg::ALPHA_RESET;
         prev_m_ff    <= '0;
         prev_t_ff    <= '0;
         est_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alpha_ff     <= alpha_in;
         prev_m_ff    <= prev_m_in;
         prev_t_ff    <= prev_t_in;
         est_ff       <= est_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dm_ff       <= dm_in;
      dt_ff       <= dt_in;
      rem_ff      <= rem_in;
      qn_ff       <= qn_in;
      prod_ff     <= prod_in;
      shift_ff    <= shift_in;
      acc_ff      <= acc_in;
      fallback_ff <= fallback_in;
      sat_ff      <= sat_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/cskew_checker.sv =====
// cskew_checker: port-level assertions for clock_skew_ratio_estimator
// depends on cskew_pkg; bound to the top level at the end of this file

module cskew_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input cskew_pkg::rsp_payload_type rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready high right after a transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.was_fallback |-> !rsp_data.saturated)
      else $error("fallback result flagged saturated");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.was_fallback |-> rsp_data.skew_ratio == cskew_pkg::ONE_FIXED)
      else $error("fallback result is not 1.0");

endmodule

bind clock_skew_ratio_estimator cskew_checker u_cskew_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/cskew_checker.sv =====
`timescale 1ns / 100ps
// cskew_scoreboard: watches the req, rsp and csr ports of the clock skew ratio estimator,
// predicts each result from its own copy of the state and compares field by field
// depends on cskew_pkg

module cskew_scoreboard (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  cskew_pkg::req_payload_type          req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  cskew_pkg::rsp_payload_type          rsp_data,
   input  logic                                csr_we,
   input  logic [cskew_pkg::ALPHA_BITS-1:0]    csr_wdata,
   output int                                  mismatch_count,
   output int                                  outstanding
);

   logic [cskew_pkg::ALPHA_BITS-1:0] alpha;
   logic [cskew_pkg::TS_BITS-1:0]    last_master;
   logic [cskew_pkg::TS_BITS-1:0]    last_tag;
   logic [cskew_pkg::RATIO_BITS-1:0] estimate;
   cskew_pkg::rsp_payload_type       pending_skew[$];

   function automatic cskew_pkg::rsp_payload_type next_skew(
      input cskew_pkg::req_payload_type item);
      logic [cskew_pkg::TS_BITS-1:0]    d_master;
      logic [cskew_pkg::TS_BITS-1:0]    d_tag;
      logic [79:0]                      quotient;
      logic [cskew_pkg::RATIO_BITS-1:0] ratio;
      logic [63:0]                      weight;
      logic [63:0]                      acc;
      cskew_pkg::rsp_payload_type       res;
      res = '0;
      if (last_master == '0 || last_tag == '0) begin
         estimate = cskew_pkg::ONE_FIXED;
         res.was_fallback = 1'b1;
      end else begin
         d_master = item.master_tx_time - last_master;
         d_tag    = item.tag_rx_time - last_tag;
         weight   = (alpha > cskew_pkg::ALPHA_ONE) ? 64'(cskew_pkg::ALPHA_ONE) : 64'(alpha);
         if (d_tag == '0) begin
            ratio = cskew_pkg::RATIO_MAX;
            res.saturated = 1'b1;
         end else begin
            quotient = {8'd0, d_master, 32'd0} / 80'(d_tag);
            if (quotient > 80'(cskew_pkg::RATIO_MAX)) begin
               ratio = cskew_pkg::RATIO_MAX;
               res.saturated = 1'b1;
            end else begin
               ratio = quotient[cskew_pkg::RATIO_BITS-1:0];
            end
         end
         acc = weight * 64'(ratio) + (64'(cskew_pkg::ALPHA_ONE) - weight) * 64'(estimate)
               + 64'(cskew_pkg::ROUND_HALF);
         estimate = acc[cskew_pkg::ALPHA_SHIFT +: cskew_pkg::RATIO_BITS];
      end
      last_master = item.master_tx_time;
      last_tag    = item.tag_rx_time;
      res.skew_ratio = estimate;
      return res;
   endfunction

   always @(posedge clock) begin
      cskew_pkg::rsp_payload_type want;
      if (reset) begin
         alpha          = cskew_pkg::ALPHA_RESET;
         last_master    = '0;
         last_tag       = '0;
         estimate       = '0;
         mismatch_count = 0;
         pending_skew.delete();
      end else begin
         if (csr_we)
            alpha = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (pending_skew.size() == 0) begin
               $display("%0t: result with none expected, got %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = pending_skew.pop_front();
               if (rsp_data.skew_ratio !== want.skew_ratio) begin
                  $display("%0t: skew_ratio expected %h got %h",
                           $time, want.skew_ratio, rsp_data.skew_ratio);
                  mismatch_count++;
               end
               if (rsp_data.was_fallback !== want.was_fallback) begin
                  $display("%0t: was_fallback expected %b got %b",
                           $time, want.was_fallback, rsp_data.was_fallback);
                  mismatch_count++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $display("%0t: saturated expected %b got %b",
                           $time, want.saturated, rsp_data.saturated);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            pending_skew.push_back(next_skew(req_data));
      end
      outstanding = pending_skew.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// testbench: drives timestamp pairs and smoothing weights into clock_skew_ratio_estimator
// and gives the verdict; depends on cskew_pkg and cskew_scoreboard

module testbench;

   localparam int TSB = cskew_pkg::TS_BITS;
   localparam int AB  = cskew_pkg::ALPHA_BITS;
   localparam logic [TSB-1:0] TS_MAX = '1;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   cskew_pkg::req_payload_type req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   cskew_pkg::rsp_payload_type rsp_data;
   logic                       csr_we = 1'b0;
   logic [AB-1:0]              csr_wdata = '0;

   int                         mismatch_count;
   int                         outstanding;
   int                         send_idle_pct = 16;
   int                         recv_idle_pct = 54;
   logic [TSB-1:0]             mt_now = '0;
   logic [TSB-1:0]             tt_now = '0;

   clock_skew_ratio_estimator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   cskew_scoreboard skew_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [TSB-1:0] rand_ts();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[TSB-1:0];
   endfunction

   task automatic send_ts(input logic [TSB-1:0] master, input logic [TSB-1:0] tag);
      cskew_pkg::req_payload_type item;
      item.master_tx_time = master;
      item.tag_rx_time    = tag;
      mt_now = master;
      tt_now = tag;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_drifted();
      logic [TSB-1:0] d_tag;
      logic [TSB-1:0] drift;
      d_tag = rand_ts() >> $urandom_range(1, 39);
      if (d_tag == '0)
         d_tag = 1;
      drift = d_tag >> $urandom_range(3, 24);
      if ($urandom_range(1))
         send_ts(mt_now + d_tag + drift, tt_now + d_tag);
      else
         send_ts(mt_now + d_tag - drift, tt_now + d_tag);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_alpha(input logic [AB-1:0] value);
      settle();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [TSB-1:0] d_tag;
      int             pick;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_ts(100, 200);
      send_ts(1_000_100, 1_000_200);
      send_ts(1_000_600, 1_000_200);
      send_ts(1_040_600, 1_001_200);
      send_ts(1_056_599, 1_002_200);
      send_ts(1_072_599, 1_003_200);
      send_ts(1_072_599, 1_004_200);
      send_ts(TS_MAX - 10, TS_MAX - 5);
      send_ts(20, 30);
      send_ts(TS_MAX, 31);
      send_ts(TS_MAX, 30);
      send_ts(0, 29);
      send_ts(5, 40);
      send_ts(10, 0);
      send_ts(20, 50);
      send_ts(TS_MAX, TS_MAX);

      set_alpha('0);
      send_drifted();
      send_drifted();
      set_alpha(cskew_pkg::ALPHA_ONE);
      send_drifted();
      send_drifted();
      set_alpha('1);
      send_drifted();
      send_drifted();
      set_alpha(cskew_pkg::ALPHA_ONE + AB'(1));
      send_drifted();

      for (int phase = 0; phase < 3; phase++) begin
         settle();
         case (phase)
            0: begin
               send_idle_pct = 16;
               recv_idle_pct = 54;
               set_alpha(AB'($urandom_range(0, 65536)));
            end
            1: begin
               send_idle_pct = 54;
               recv_idle_pct = 16;
               set_alpha(AB'($urandom_range(0, 131071)));
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               set_alpha(cskew_pkg::ALPHA_RESET);
            end
         endcase
         for (int n = 0; n < 134; n++) begin
            if ($urandom_range(63) == 0)
               settle();
            pick = $urandom_range(99);
            if (pick < 75) begin
               send_drifted();
            end else if (pick < 85) begin
               send_ts(rand_ts(), rand_ts());
            end else if (pick < 90) begin
               send_ts(mt_now + TSB'($urandom_range(0, 5000)), tt_now);
            end else if (pick < 95) begin
               if ($urandom_range(1))
                  send_ts(0, tt_now + 1000);
               else
                  send_ts(mt_now + 1000, 0);
            end else begin
               d_tag = TSB'($urandom_range(1, 1 << 20));
               send_ts(mt_now + d_tag * TSB'($urandom_range(16, 40)), tt_now + d_tag);
            end
         end
      end

      settle();
      repeat (64) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
